// ===== design/rps_pkg.sv =====
// Shared constants for the streaming pattern search block.
package rps_pkg;

   localparam int MAX_PATTERN   = 64;
   localparam int ALPHABET_SIZE = 256;
   localparam int POSITION_BITS = 32;

   localparam int IDX_W  = $clog2(MAX_PATTERN);       // ring / pattern address
   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);   // length, shift, countdown
   localparam int SYM_W  = $clog2(ALPHABET_SIZE);     // shift table address
   localparam int POS_W  = POSITION_BITS;

   // fixed field widths
   localparam int CFG_W   = 7;
   localparam int PIDX_W  = 6;
   localparam int BYTE_W  = 8;
   localparam int MATCH_W = 32;
   localparam int REQ_DATA_W = 16;

   // req_tuser codes
   localparam logic REQ_PATTERN = 1'b0;
   localparam logic REQ_TEXT    = 1'b1;

endpackage

// ===== design/raita_pattern_search.sv =====
// Top level: streaming Raita matcher with pattern, shift and text-window memories.
// A pattern byte or a text byte that triggers no check leaves the input ready.
// A text byte that triggers a window check holds the input until the check
// resolves: one RAM read per compared byte, early exit on mismatch,
// plus any wait of a match for the result register to free up.
// Checks are paced by the single read port of the window and pattern RAMs.
// Reset (synchronous): control, position and valid bits clear, countdown and
// pattern_length return to 1; RAM contents are not cleared, no clearing pass.
module raita_pattern_search
   import rps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request transaction
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [5:0] pattern_index, [13:6] data_byte, pad
   input  logic                  req_tuser,  // [0] req_type
   // response transaction
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [MATCH_W-1:0]    rsp_tdata,  // [31:0] match_start
   // pattern_length register
   input  logic                  csr_we,
   input  logic [CFG_W-1:0]      csr_wdata
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_CHECK = 1'b1;

   // request fields
   logic [PIDX_W-1:0] pidx;
   logic [BYTE_W-1:0] data_byte;
   logic [SYM_W-1:0]  sym;
   assign pidx      = req_tdata[PIDX_W-1:0];
   assign data_byte = req_tdata[PIDX_W +: BYTE_W];
   assign sym       = SYM_W'(data_byte);

   // registers
   logic                   state_ff, state_in;
   logic [CFG_W-1:0]       plen_ff;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [LEN_W-1:0]       cdown_ff, cdown_in;
   logic [ALPHABET_SIZE-1:0] swr_ff, swr_in;   // shift entry written
   logic [MAX_PATTERN-1:0] rvalid_ff, rvalid_in; // ring slot written since restart
   logic                   sw_hit_ff, sw_hit_in;
   logic [LEN_W-1:0]       step_ff, step_in;
   logic                   pend_ff, pend_in;
   logic                   pend_last_ff, pend_last_in;
   logic                   rv_hit_ff, rv_hit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MATCH_W-1:0]     rsp_data_ff, rsp_data_in;

   // effective length: 0 acts as 1, clamp to MAX_PATTERN
   logic [LEN_W-1:0] m_eff;
   always_comb begin
      if (plen_ff == '0) begin
         m_eff = LEN_W'(1);
      end else if (int'(plen_ff) > MAX_PATTERN) begin
         m_eff = LEN_W'(MAX_PATTERN);
      end else begin
         m_eff = LEN_W'(plen_ff);
      end
   end

   logic acc, acc_pat, acc_txt, restart;
   assign req_tready = (state_ff == ST_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign acc_pat    = acc && (req_tuser == REQ_PATTERN);
   assign acc_txt    = acc && (req_tuser == REQ_TEXT);
   assign restart    = acc_pat && (pidx == '0);

   logic pat_wr, shf_wr;
   assign pat_wr = acc_pat && (int'(pidx) < MAX_PATTERN);
   assign shf_wr = acc_pat && ((int'(pidx) + 1) < int'(m_eff));

   logic [LEN_W-1:0] shf_val;
   assign shf_val = LEN_W'(m_eff - LEN_W'(1) - LEN_W'(pidx));

   // compare order: last, middle, first, then 1 .. m-2
   logic [LEN_W-1:0] k_sel, last_step;
   always_comb begin
      case (step_ff)
         LEN_W'(0): k_sel = LEN_W'(m_eff - LEN_W'(1));
         LEN_W'(1): k_sel = m_eff >> 1;
         LEN_W'(2): k_sel = '0;
         default:   k_sel = LEN_W'(step_ff - LEN_W'(2));
      endcase
      last_step = (m_eff < LEN_W'(3)) ? LEN_W'(2) : m_eff;
   end

   logic [IDX_W-1:0] ring_raddr, pat_raddr;
   assign ring_raddr = IDX_W'(head_ff - IDX_W'(m_eff) + IDX_W'(k_sel));
   assign pat_raddr  = IDX_W'(k_sel);

   logic [BYTE_W-1:0] ring_dout, pat_dout, ring_byte;
   logic [LEN_W-1:0]  shf_dout;
   logic              issue;

   rps_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PATTERN)) u_ring (
      .clock   (clock),
      .wr_en   (acc_txt),
      .wr_addr (head_ff),
      .wr_data (data_byte),
      .rd_en   (issue),
      .rd_addr (ring_raddr),
      .rd_data (ring_dout)
   );

   rps_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PATTERN)) u_pattern (
      .clock   (clock),
      .wr_en   (pat_wr),
      .wr_addr (IDX_W'(pidx)),
      .wr_data (data_byte),
      .rd_en   (issue),
      .rd_addr (pat_raddr),
      .rd_data (pat_dout)
   );

   // shift entry is read on each text byte and held through the check
   rps_ram #(.WIDTH(LEN_W), .DEPTH(ALPHABET_SIZE)) u_shift (
      .clock   (clock),
      .wr_en   (shf_wr),
      .wr_addr (sym),
      .wr_data (shf_val),
      .rd_en   (acc_txt),
      .rd_addr (sym),
      .rd_data (shf_dout)
   );

   // unwritten ring slots read as zero
   assign ring_byte = rv_hit_ff ? ring_dout : '0;

   logic out_free, bytes_eq;
   logic [POS_W-1:0] start_pos;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign bytes_eq  = (ring_byte == pat_dout);
   assign start_pos = POS_W'(pos_ff - POS_W'(m_eff) + POS_W'(1));

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      pos_in       = pos_ff;
      cdown_in     = cdown_ff;
      swr_in       = swr_ff;
      rvalid_in    = rvalid_ff;
      sw_hit_in    = sw_hit_ff;
      step_in      = step_ff;
      pend_in      = 1'b0;
      pend_last_in = 1'b0;
      rv_hit_in    = rv_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      issue        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (acc_pat) begin
               if (restart) begin
                  swr_in    = '0;
                  rvalid_in = '0;
                  head_in   = '0;
                  pos_in    = '0;
                  cdown_in  = m_eff;
               end
               if (shf_wr) begin
                  swr_in[sym] = 1'b1;
               end
            end else if (acc_txt) begin
               rvalid_in[head_ff] = 1'b1;
               head_in   = (int'(head_ff) == MAX_PATTERN - 1) ? '0
                                                               : IDX_W'(head_ff + IDX_W'(1));
               sw_hit_in = swr_ff[sym];
               if (cdown_ff <= LEN_W'(1)) begin
                  state_in = ST_CHECK;
                  step_in  = '0;
               end else begin
                  cdown_in = LEN_W'(cdown_ff - LEN_W'(1));
                  pos_in   = POS_W'(pos_ff + POS_W'(1));
               end
            end
         end
         ST_CHECK: begin
            if (pend_ff && (!bytes_eq || pend_last_ff)) begin
               // window resolved: wait for a free output slot only on a match
               if (!bytes_eq || out_free) begin
                  state_in = ST_IDLE;
                  cdown_in = sw_hit_ff ? shf_dout : m_eff;
                  pos_in   = POS_W'(pos_ff + POS_W'(1));
                  if (bytes_eq) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = MATCH_W'(start_pos);
                  end
               end else begin
                  pend_in      = 1'b1;
                  pend_last_in = 1'b1;
               end
            end else begin
               issue        = 1'b1;
               rv_hit_in    = rvalid_ff[ring_raddr];
               pend_in      = 1'b1;
               pend_last_in = (step_ff == last_step);
               step_in      = LEN_W'(step_ff + LEN_W'(1));
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         plen_ff      <= CFG_W'(1);
         head_ff      <= '0;
         pos_ff       <= '0;
         cdown_ff     <= LEN_W'(1);
         swr_ff       <= '0;
         rvalid_ff    <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            plen_ff <= csr_wdata;
         end
         head_ff      <= head_in;
         pos_ff       <= pos_in;
         cdown_ff     <= cdown_in;
         swr_ff       <= swr_in;
         rvalid_ff    <= rvalid_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sw_hit_ff   <= sw_hit_in;
      step_ff     <= step_in;
      rv_hit_ff   <= rv_hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // text byte with expired countdown must start a window check
   a_check_start: assert property (@(posedge clock) disable iff (reset)
      (acc_txt && (cdown_ff <= LEN_W'(1))) |=> (state_ff == ST_CHECK))
      else $error("window check not started");

   // countdown steps down by one on a byte that triggers no check
   a_cdown_dec: assert property (@(posedge clock) disable iff (reset)
      (acc_txt && (cdown_ff > LEN_W'(1))) |=> (cdown_ff == $past(cdown_ff) - LEN_W'(1)))
      else $error("countdown did not decrement");

   // a new result only comes out of a finished check
   a_rsp_from_check: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_CHECK))
      else $error("result raised outside a check");

   // restart clears the window head, the position and the ring valid bits
   a_restart_clear: assert property (@(posedge clock) disable iff (reset)
      restart |=> ((head_ff == '0) && (pos_ff == '0) && (rvalid_ff == '0)))
      else $error("restart did not clear window state");

   // a pending compare never coexists with an idle state
   a_pend_in_check: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_CHECK))
      else $error("compare pending while idle");

endmodule

// ===== design/rps_ram.sv =====
// Generic simple dual-port RAM with registered read.
module rps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
